/* hdl/itp_pkg.sv */
// Types, operator codes and priority functions of the infix to postfix converter.
// Shared by the controller, the datapath and the top level. No dependencies.
package itp_pkg;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_DIV  = 8'h2F;
	localparam logic [7:0] CH_MOD  = 8'h25;

	localparam logic [4:0] PRIO_LPAR_IN = 5'd20;
	localparam logic [4:0] PRIO_ADD     = 5'd12;
	localparam logic [4:0] PRIO_MUL     = 5'd13;
	localparam logic [4:0] PRIO_NONE    = 5'd0;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_LPAR = 3'd1,
		OP_ADD  = 3'd2,
		OP_SUB  = 3'd3,
		OP_MUL  = 3'd4,
		OP_DIV  = 3'd5,
		OP_MOD  = 3'd6
	} op_code_t;

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0,
		FAULT_RPAR = 2'd1,
		FAULT_OVF  = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		OSEL_NONE = 2'd0,
		OSEL_TOP  = 2'd1,
		OSEL_SYM  = 2'd2
	} osel_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EVAL  = 2'd1,
		ST_FETCH = 2'd2
	} state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] symbol;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       has_symbol;
		logic       last;
		fault_t     fault;
	} out_item_t;

	typedef struct packed {
		logic   load;
		logic   emit;
		logic   pop;
		logic   push;
		osel_t  osel;
		logic   last;
		fault_t fault;
	} itp_cmd_t;

	typedef struct packed {
		logic flush;
		logic rpar;
		logic operand;
		logic sp_zero;
		logic sp_one;
		logic full;
		logic top_lpar;
		logic yields;
		logic out_free;
	} itp_status_t;

	function automatic op_code_t classify(input logic [7:0] c);
		op_code_t r;
		case (c)
			CH_LPAR: r = OP_LPAR;
			CH_ADD:  r = OP_ADD;
			CH_SUB:  r = OP_SUB;
			CH_MUL:  r = OP_MUL;
			CH_DIV:  r = OP_DIV;
			CH_MOD:  r = OP_MOD;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] code_char(input op_code_t c);
		logic [7:0] r;
		case (c)
			OP_LPAR: r = CH_LPAR;
			OP_ADD:  r = CH_ADD;
			OP_SUB:  r = CH_SUB;
			OP_MUL:  r = CH_MUL;
			OP_DIV:  r = CH_DIV;
			OP_MOD:  r = CH_MOD;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] code_isp(input op_code_t c);
		logic [4:0] r;
		case (c) inside
			OP_ADD, OP_SUB:         r = PRIO_ADD;
			OP_MUL, OP_DIV, OP_MOD: r = PRIO_MUL;
			default:                r = PRIO_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] code_icp(input op_code_t c);
		logic [4:0] r;
		case (c) inside
			OP_LPAR:                r = PRIO_LPAR_IN;
			OP_ADD, OP_SUB:         r = PRIO_ADD;
			OP_MUL, OP_DIV, OP_MOD: r = PRIO_MUL;
			default:                r = PRIO_NONE;
		endcase
		return r;
	endfunction

endpackage

/* hdl/itp_ctrl.sv */
// Controller state machine of the infix to postfix converter.
// Depends on itp_pkg; drives the datapath through itp_cmd_t and reads itp_status_t.
module itp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itp_pkg::itp_status_t st,
	output itp_pkg::itp_cmd_t    cmd
);
	import itp_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_EVAL;
				end
			end
			ST_FETCH: begin
				state_next = ST_EVAL;
			end
			ST_EVAL: begin
				if (st.flush) begin
					if (st.out_free) begin
						state_next = (st.sp_zero || st.sp_one) ? ST_IDLE : ST_FETCH;
					end
				end else if (st.rpar) begin
					if (st.sp_zero) begin
						if (st.out_free) begin
							state_next = ST_IDLE;
						end
					end else if (st.top_lpar) begin
						state_next = ST_IDLE;
					end else if (st.out_free) begin
						state_next = ST_FETCH;
					end
				end else if (st.operand) begin
					if (st.out_free) begin
						state_next = ST_IDLE;
					end
				end else if (!st.sp_zero && st.yields) begin
					if (st.out_free) begin
						state_next = ST_FETCH;
					end
				end else if (st.full) begin
					if (st.out_free) begin
						state_next = ST_IDLE;
					end
				end else begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.osel  = OSEL_NONE;
		cmd.fault = FAULT_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EVAL: begin
				if (st.flush) begin
					cmd.emit = st.out_free;
					cmd.pop  = st.out_free && !st.sp_zero;
					cmd.osel = st.sp_zero ? OSEL_NONE : OSEL_TOP;
					cmd.last = st.sp_zero || st.sp_one;
				end else if (st.rpar) begin
					if (st.sp_zero) begin
						cmd.emit  = st.out_free;
						cmd.fault = FAULT_RPAR;
					end else if (st.top_lpar) begin
						cmd.pop = 1'b1;
					end else begin
						cmd.emit = st.out_free;
						cmd.pop  = st.out_free;
						cmd.osel = OSEL_TOP;
					end
				end else if (st.operand) begin
					cmd.emit = st.out_free;
					cmd.osel = OSEL_SYM;
				end else if (!st.sp_zero && st.yields) begin
					cmd.emit = st.out_free;
					cmd.pop  = st.out_free;
					cmd.osel = OSEL_TOP;
				end else if (st.full) begin
					cmd.emit  = st.out_free;
					cmd.fault = FAULT_OVF;
				end else begin
					cmd.push = 1'b1;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* hdl/itp_dp.sv */
// Datapath of the infix to postfix converter: item register, operator stack
// memory, stack pointer and output register. Depends on itp_pkg.
module itp_dp #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itp_pkg::in_item_t    in_data,
	input  itp_pkg::itp_cmd_t    cmd,
	output itp_pkg::itp_status_t st,
	output logic                 out_valid,
	input  logic                 out_ready,
	output itp_pkg::out_item_t   out_data
);
	import itp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH + 1);
	localparam logic [SW-1:0] SP_ONE  = SW'(1);
	localparam logic [SW-1:0] SP_FULL = SW'(STACK_DEPTH);

	op_code_t        mem [STACK_DEPTH];
	op_code_t        top_q;
	logic [SW-1:0]   sp_q;
	logic            kind_q;
	logic [7:0]      sym_q;
	logic            out_valid_q;
	out_item_t       out_q;
	logic [SW-1:0]   sp_dec;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	op_code_t        in_code;
	out_item_t       out_next;

	assign sp_dec  = sp_q - SP_ONE;
	assign rd_addr = sp_dec[AW-1:0];
	assign wr_addr = sp_q[AW-1:0];
	assign in_code = classify(sym_q);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= in_code;
		end
		top_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_data.kind;
			sym_q  <= in_data.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.pop) begin
			sp_q <= sp_dec;
		end else if (cmd.push) begin
			sp_q <= sp_q + SP_ONE;
		end
	end

	always_comb begin
		out_next            = '0;
		out_next.last       = cmd.last;
		out_next.fault      = cmd.fault;
		out_next.has_symbol = (cmd.osel != OSEL_NONE);
		case (cmd.osel)
			OSEL_TOP: out_next.out_symbol = code_char(top_q);
			OSEL_SYM: out_next.out_symbol = sym_q;
			default:  out_next.out_symbol = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= out_next;
		end
	end

	always_comb begin
		st.flush    = kind_q || (sym_q == CH_HASH);
		st.rpar     = (sym_q == CH_RPAR);
		st.operand  = (in_code == OP_NONE);
		st.sp_zero  = (sp_q == '0);
		st.sp_one   = (sp_q == SP_ONE);
		st.full     = (sp_q >= SP_FULL);
		st.top_lpar = (top_q == OP_LPAR);
		st.yields   = (code_icp(in_code) <= code_isp(top_q));
		st.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hdl/infix_to_postfix_converter.sv */
// Each item is loaded in IDLE and evaluated in EVAL; every operator that it releases to the
// output is popped in EVAL, and FETCH then waits for the registered stack memory read port
// before EVAL runs again. A flush pops the whole stack in the same loop. Output stalls hold
// EVAL. A new item is taken only in IDLE, after the last one is through.
// Reset clears the stack pointer to zero (empty stack) and the output valid;
// stack entries are not cleared.
// Top level: joins itp_ctrl and itp_dp. Depends on itp_pkg.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  itp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output itp_pkg::out_item_t out_data
);
	import itp_pkg::*;

	itp_cmd_t    cmd;
	itp_status_t st;

	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	itp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* bench/infix_to_postfix_converter_tb.sv */
`timescale 1ns / 100ps
// Testbench for infix_to_postfix_converter: drives infix characters and checks every
// postfix result against an operator-stack predictor. Depends on itp_pkg and the RTL.
module infix_to_postfix_converter_tb;
	import itp_pkg::*;

	localparam int STACK_DEPTH = 32;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	in_item_t infix_queue[$];
	out_item_t postfix_due[$];
	op_code_t op_stack[STACK_DEPTH];
	int op_depth = 0;

	int queued = 0;
	int taken_in = 0;
	int rx_count = 0;
	int errors = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	int stall_cycles = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit hold_done = 1'b0;
	out_item_t want;

	infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic op_code_t op_for(input logic [7:0] c);
		case (c)
			CH_LPAR: return OP_LPAR;
			CH_ADD:  return OP_ADD;
			CH_SUB:  return OP_SUB;
			CH_MUL:  return OP_MUL;
			CH_DIV:  return OP_DIV;
			CH_MOD:  return OP_MOD;
			default: return OP_NONE;
		endcase
	endfunction

	function automatic logic [7:0] symbol_of(input op_code_t op);
		case (op)
			OP_LPAR: return CH_LPAR;
			OP_ADD:  return CH_ADD;
			OP_SUB:  return CH_SUB;
			OP_MUL:  return CH_MUL;
			OP_DIV:  return CH_DIV;
			OP_MOD:  return CH_MOD;
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [4:0] arriving_rank(input op_code_t op);
		if (op == OP_LPAR)
			return PRIO_LPAR_IN;
		if (op == OP_ADD || op == OP_SUB)
			return PRIO_ADD;
		return PRIO_MUL;
	endfunction

	function automatic logic [4:0] waiting_rank(input op_code_t op);
		if (op == OP_ADD || op == OP_SUB)
			return PRIO_ADD;
		if (op == OP_MUL || op == OP_DIV || op == OP_MOD)
			return PRIO_MUL;
		return PRIO_NONE;
	endfunction

	task automatic expect_out(input logic [7:0] sym, input logic has, input logic fin,
			input fault_t f);
		out_item_t r;
		r.out_symbol = sym;
		r.has_symbol = has;
		r.last = fin;
		r.fault = f;
		postfix_due.push_back(r);
	endtask

	task automatic pop_and_expect(input logic fin_at_bottom);
		op_code_t op;
		op = op_stack[op_depth - 1];
		op_depth--;
		expect_out(symbol_of(op), 1'b1, fin_at_bottom && op_depth == 0, FAULT_NONE);
	endtask

	// Advances the predicted operator stack by one accepted item.
	task automatic convert_symbol(input in_item_t it);
		op_code_t op;
		if (it.kind || it.symbol == CH_HASH) begin
			if (op_depth == 0)
				expect_out(8'd0, 1'b0, 1'b1, FAULT_NONE);
			while (op_depth > 0)
				pop_and_expect(1'b1);
		end else if (it.symbol == CH_RPAR) begin
			while (op_depth > 0 && op_stack[op_depth - 1] != OP_LPAR)
				pop_and_expect(1'b0);
			if (op_depth == 0)
				expect_out(8'd0, 1'b0, 1'b0, FAULT_RPAR);
			else
				op_depth--;
		end else begin
			op = op_for(it.symbol);
			if (op == OP_NONE) begin
				expect_out(it.symbol, 1'b1, 1'b0, FAULT_NONE);
			end else begin
				while (op_depth > 0 &&
						arriving_rank(op) <= waiting_rank(op_stack[op_depth - 1]))
					pop_and_expect(1'b0);
				if (op_depth >= STACK_DEPTH) begin
					expect_out(8'd0, 1'b0, 1'b0, FAULT_OVF);
				end else begin
					op_stack[op_depth] = op;
					op_depth++;
				end
			end
		end
	endtask

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic push_item(input logic k, input logic [7:0] s);
		in_item_t it;
		it.kind = k;
		it.symbol = s;
		infix_queue.push_back(it);
		queued++;
	endtask

	task automatic put_char(input logic [7:0] c);
		push_item(1'b0, c);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic put_end();
		if ($urandom_range(0, 1))
			push_item(1'b1, 8'($urandom_range(0, 255)));
		else
			put_char(CH_HASH);
	endtask

	function automatic logic [7:0] pick_operand();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (op_for(c) != OP_NONE || c == CH_RPAR || c == CH_HASH)
			c = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) != 0)
			c = 8'h61 + 8'($urandom_range(0, 25));
		return c;
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 4))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			3: return CH_DIV;
			default: return CH_MOD;
		endcase
	endfunction

	task automatic gen_expression();
		int terms;
		int open;
		terms = $urandom_range(1, 6);
		open = 0;
		for (int k = 0; k < terms; k++) begin
			while ($urandom_range(0, 3) == 0 && open < 6) begin
				put_char(CH_LPAR);
				open++;
			end
			put_char(pick_operand());
			while (open > 0 && $urandom_range(0, 2) == 0) begin
				put_char(CH_RPAR);
				open--;
			end
			if (k != terms - 1)
				put_char(pick_operator());
		end
		if ($urandom_range(0, 3) != 0) begin
			while (open > 0) begin
				put_char(CH_RPAR);
				open--;
			end
		end
		put_end();
	endtask

	// Nesting that can run the operator stack past its depth, then a full flush.
	task automatic gen_deep();
		int n;
		n = $urandom_range(28, 40);
		for (int i = 0; i < n; i++) begin
			put_char(CH_LPAR);
			if ($urandom_range(0, 1)) begin
				put_char(pick_operand());
				put_char(pick_operator());
			end
		end
		put_end();
	endtask

	task automatic gen_noise();
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				put_char(CH_RPAR);
			else
				push_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_random(input bit allow_deep);
		int r;
		r = $urandom_range(0, 19);
		if (r < 15)
			gen_expression();
		else if (r < 19 || !allow_deep)
			gen_noise();
		else
			gen_deep();
	endtask

	task automatic settle();
		while (taken_in != queued)
			@(posedge clk);
		while (postfix_due.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				convert_symbol(in_data);
				taken_in++;
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (infix_queue.size() != 0) begin
					in_data <= infix_queue.pop_front();
					in_valid <= 1'b1;
					if ($urandom_range(0, 31) == 0)
						tx_burst = ~tx_burst;
					tx_gap = draw_gap(tx_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap = 0;
			rx_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				rx_count++;
				if (postfix_due.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: %h", $time, out_data);
				end else begin
					want = postfix_due.pop_front();
					if (out_data.out_symbol !== want.out_symbol ||
							out_data.has_symbol !== want.has_symbol ||
							out_data.last !== want.last || out_data.fault !== want.fault) begin
						errors++;
						$display("%0t: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
							$time, want.out_symbol, want.has_symbol, want.last, want.fault,
							out_data.out_symbol, out_data.has_symbol, out_data.last,
							out_data.fault);
					end
				end
				if ($urandom_range(0, 31) == 0)
					rx_burst = ~rx_burst;
				rx_gap = draw_gap(rx_burst);
				if (rx_count >= HOLD_AT && !hold_done) begin
					hold_done = 1'b1;
					rx_hold = HOLD_CYCLES;
				end
			end else if (rx_hold > 0) begin
				rx_hold--;
			end else if (rx_gap > 0) begin
				rx_gap--;
			end
			out_ready <= (rx_gap == 0 && rx_hold == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
			stall_cycles++;
		else
			stall_cycles = 0;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		put_text("a+b*c-(d/e%f)");
		push_item(1'b1, 8'hFF);
		put_char(8'h00);
		put_char(8'hFF);
		put_char(CH_RPAR);
		put_text("+)");
		push_item(1'b1, CH_RPAR);
		put_text("#(*#");
		while (queued < 80)
			add_random(1'b0);

		// The sender stops here until every result of the first part is back.
		settle();
		gen_deep();
		while (queued < 360)
			add_random(1'b1);
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
hdl/itp_pkg.sv
hdl/itp_ctrl.sv
hdl/itp_dp.sv
hdl/infix_to_postfix_converter.sv
bench/infix_to_postfix_converter_tb.sv
